@@ sv/esc_pkg.sv @@
package esc_pkg;

	localparam int unsigned NumRegs = 6;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 64;

	localparam logic [CfgIdxW-1:0] RegTempCalib  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegPressCalA  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegPressCalB  = 3'd2;
	localparam logic [CfgIdxW-1:0] RegPressCalC  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegHumCalA    = 3'd4;
	localparam logic [CfgIdxW-1:0] RegHumCalB    = 3'd5;

	localparam int unsigned DivLatency = 32;

	// 32-bit wrapping multiply.
	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

	// Arithmetic right shift of a 32-bit word.
	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

endpackage

@@ sv/esc_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, 32 stages.
// Tag data travels alongside; a global enable freezes every stage.
module esc_divider
	import esc_pkg::*;
#(
	parameter int unsigned TagW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [31:0]     in_num,
	input  logic [31:0]     in_den,
	input  logic [TagW-1:0] in_tag,
	output logic            out_valid,
	output logic [31:0]     out_quot,
	output logic [TagW-1:0] out_tag
);

	logic [DivLatency:0]           vld_s;
	logic [31:0]                   rem_s [DivLatency+1];
	logic [31:0]                   num_s [DivLatency+1];
	logic [31:0]                   den_s [DivLatency+1];
	logic [TagW-1:0]               tag_s [DivLatency+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign num_s[0] = in_num;
	assign den_s[0] = in_den;
	assign tag_s[0] = in_tag;

	for (genvar i = 0; i < DivLatency; i++) begin : g_stage
		logic [32:0] trial;
		logic [32:0] diff;
		always_comb begin
			trial = {rem_s[i], num_s[i][31]};
			diff  = trial - {1'b0, den_s[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[32]) begin
					rem_s[i+1] <= diff[31:0];
					num_s[i+1] <= {num_s[i][30:0], 1'b1};
				end else begin
					rem_s[i+1] <= trial[31:0];
					num_s[i+1] <= {num_s[i][30:0], 1'b0};
				end
				den_s[i+1] <= den_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = vld_s[DivLatency];
	assign out_quot  = num_s[DivLatency];
	assign out_tag   = tag_s[DivLatency];

endmodule

@@ sv/env_sensor_compensation.sv @@
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------------
// input     | valid / stall      | raw_temperature, raw_pressure, raw_humidity
// output    | out_valid/out_stall| temp_centideg, pressure_pa, humidity_q10, divide_error
// config    | cfg_we             | cfg_index, cfg_data
//
// One word enters per cycle when the output side is not stalling. The pipe has
// 8 front stages, 32 divider stages and 3 back stages, the divider being the
// bit-per-stage pressure divider. Every stage carries a valid bit cleared by
// arst_n. A stall freezes the whole pipe and the output register holds its word;
// stall is out_stall && out_valid, so nothing is lost or repeated.
module env_sensor_compensation
	import esc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  logic [19:0]         raw_temperature,
	input  logic [19:0]         raw_pressure,
	input  logic [15:0]         raw_humidity,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  temp_centideg,
	output logic [31:0]         pressure_pa,
	output logic [16:0]         humidity_q10,
	output logic                divide_error,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	// Calibration registers.
	logic [47:0] temp_cal_q;
	logic [63:0] pcal_a_q, pcal_b_q;
	logic [15:0] pcal_c_q;
	logic [47:0] hcal_a_q;
	logic [23:0] hcal_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			pcal_a_q   <= '0;
			pcal_b_q   <= '0;
			pcal_c_q   <= '0;
			hcal_a_q   <= '0;
			hcal_b_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegTempCalib: temp_cal_q <= cfg_data[47:0];
				RegPressCalA: pcal_a_q   <= cfg_data;
				RegPressCalB: pcal_b_q   <= cfg_data;
				RegPressCalC: pcal_c_q   <= cfg_data[15:0];
				RegHumCalA:   hcal_a_q   <= cfg_data[47:0];
				RegHumCalB:   hcal_b_q   <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1, h2, h3, h4, h5, h6;
	assign t1 = {16'd0, temp_cal_q[15:0]};
	assign t2 = sx16(temp_cal_q[31:16]);
	assign t3 = sx16(temp_cal_q[47:32]);
	assign p1 = {16'd0, pcal_a_q[15:0]};
	assign p2 = sx16(pcal_a_q[31:16]);
	assign p3 = sx16(pcal_a_q[47:32]);
	assign p4 = sx16(pcal_a_q[63:48]);
	assign p5 = sx16(pcal_b_q[15:0]);
	assign p6 = sx16(pcal_b_q[31:16]);
	assign p7 = sx16(pcal_b_q[47:32]);
	assign p8 = sx16(pcal_b_q[63:48]);
	assign p9 = sx16(pcal_c_q);
	assign h2 = sx16(hcal_a_q[15:0]);
	assign h4 = sx16(hcal_a_q[31:16]);
	assign h5 = sx16(hcal_a_q[47:32]);
	assign h1 = {24'd0, hcal_b_q[7:0]};
	assign h3 = {24'd0, hcal_b_q[15:8]};
	assign h6 = sx8(hcal_b_q[23:16]);

	// The whole pipe advances together whenever the output is not stalled or holds no valid word.
	logic en;
	assign en    = !out_stall || !out_valid;
	assign stall = !en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [31:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6;
	logic [31:0] ah_s1, ah_s2, ah_s3, ah_s4;

	// Stage 1: temperature products.
	logic [31:0] ta_s1, td2_s1;
	logic [31:0] at_c, d_c;
	assign at_c = {12'd0, raw_temperature};
	assign d_c  = asr32(at_c, 4) - t1;
	always_ff @(posedge clk) begin
		if (en) begin
			ta_s1  <= mul32(asr32(at_c, 3) - (t1 << 1), t2);
			td2_s1 <= mul32(d_c, d_c);
			ap_s1  <= {12'd0, raw_pressure};
			ah_s1  <= {16'd0, raw_humidity};
		end
	end

	// Stage 2: t_fine parts.
	logic [31:0] ta_s2, tb_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			ta_s2 <= asr32(ta_s1, 11);
			tb_s2 <= mul32(asr32(td2_s1, 12), t3);
			ap_s2 <= ap_s1;
			ah_s2 <= ah_s1;
		end
	end

	// Stage 3: t_fine and first pressure/humidity offsets.
	logic [31:0] tf_s3, pa_s3, pq_s3, hx_s3;
	logic [31:0] tf_c;
	assign tf_c = ta_s2 + asr32(tb_s2, 14);
	always_ff @(posedge clk) begin
		if (en) begin
			tf_s3 <= tf_c;
			pa_s3 <= asr32(tf_c, 1) - 32'd64000;
			pq_s3 <= asr32(asr32(tf_c, 1) - 32'd64000, 2);
			hx_s3 <= tf_c - 32'd76800;
			ap_s3 <= ap_s2;
			ah_s3 <= ah_s2;
		end
	end

	// Stage 4: temperature output, first products.
	logic signed [15:0] ts_s4, ts_s5, ts_s6, ts_s7, ts_s8;
	logic [31:0] qq_s4, ap5_s4, p2a_s4;
	logic [31:0] h5x_s4, xh6_s4, xh3_s4;
	logic [31:0] tsc_c;
	logic signed [31:0] tss_c;
	assign tsc_c = asr32(mul32(tf_s3, 32'd5) + 32'd128, 8);
	assign tss_c = $signed(tsc_c);
	always_ff @(posedge clk) begin
		if (en) begin
			if (tss_c > 32'sd32767)       ts_s4 <= 16'sh7fff;
			else if (tss_c < -32'sd32768) ts_s4 <= -16'sh8000;
			else                          ts_s4 <= tsc_c[15:0];
			qq_s4  <= mul32(pq_s3, pq_s3);
			ap5_s4 <= mul32(pa_s3, p5);
			p2a_s4 <= mul32(p2, pa_s3);
			h5x_s4 <= mul32(h5, hx_s3);
			xh6_s4 <= mul32(hx_s3, h6);
			xh3_s4 <= mul32(hx_s3, h3);
			ap_s4  <= ap_s3;
			ah_s4  <= ah_s3;
		end
	end

	// Stage 5: second products.
	logic [31:0] pb_s5, p3q_s5, p2a_s5, hu_s5, hm_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			pb_s5  <= mul32(asr32(qq_s4, 11), p6) + (ap5_s4 << 1);
			p3q_s5 <= mul32(p3, asr32(qq_s4, 13));
			p2a_s5 <= asr32(p2a_s4, 1);
			hu_s5  <= asr32((ah_s4 << 14) - (h4 << 20) - h5x_s4 + 32'd16384, 15);
			hm_s5  <= mul32(asr32(xh6_s4, 10), asr32(xh3_s4, 11) + 32'd32768);
			ts_s5  <= ts_s4;
			ap_s5  <= ap_s4;
		end
	end

	// Stage 6: pressure divisor product, humidity v product.
	logic [31:0] pb_s6, pdv_s6, hu_s6, hv_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			pb_s6  <= asr32(pb_s5, 2) + (p4 << 16);
			pdv_s6 <= mul32(32'd32768 + asr32(asr32(p3q_s5, 3) + p2a_s5, 18), p1);
			hu_s6  <= hu_s5;
			hv_s6  <= mul32(asr32(hm_s5, 10) + 32'd2097152, h2);
			ts_s6  <= ts_s5;
			ap_s6  <= ap_s5;
		end
	end

	// Stage 7: numerator product, humidity u*v.
	logic [31:0] pn_s7, pd_s7, hx_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			pn_s7 <= mul32((32'd1048576 - ap_s6) - asr32(pb_s6, 12), 32'd3125);
			pd_s7 <= asr32(pdv_s6, 15);
			hx_s7 <= mul32(hu_s6, asr32(hv_s6 + 32'd8192, 14));
			ts_s7 <= ts_s6;
		end
	end

	// Stage 8: humidity correction product.
	logic [31:0] pn_s8, pd_s8, hx_s8, hy_s8;
	logic [31:0] hy_c;
	assign hy_c = asr32(hx_s7, 15);
	always_ff @(posedge clk) begin
		if (en) begin
			pn_s8 <= pn_s7;
			pd_s8 <= pd_s7;
			hx_s8 <= hx_s7;
			hy_s8 <= mul32(hy_c, hy_c);
			ts_s8 <= ts_s7;
		end
	end

	// Humidity finishes before the divider, then rides in the tag.
	logic [31:0] hf_c;
	logic [16:0] hq_c;
	assign hf_c = hx_s8 - asr32(mul32(asr32(hy_s8, 7), h1), 4);
	always_comb begin
		if (hf_c[31])                    hq_c = '0;
		else if (hf_c > 32'd419430400)   hq_c = 17'(32'd419430400 >> 12);
		else                             hq_c = hf_c[28:12];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	// Divider: tag carries temperature, humidity and the zero-divisor flag.
	localparam int unsigned TagW = 16 + 17 + 1;
	logic            dv_valid;
	logic [31:0]     dv_quot;
	logic [TagW-1:0] dv_tag;
	logic            dz_c;
	assign dz_c = (pd_s8 == '0);

	esc_divider #(.TagW(TagW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.in_num   (pn_s8),
		.in_den   (dz_c ? 32'd1 : pd_s8),
		.in_tag   ({ts_s8, hq_c, dz_c}),
		.out_valid(dv_valid),
		.out_quot (dv_quot),
		.out_tag  (dv_tag)
	);

	// Back stage 1: doubled quotient and correction products.
	logic            b_v_s1, b_v_s2, b_v_s3;
	logic [31:0]     bp_s1, bu_s1, bv_s1;
	logic [TagW-1:0] bt_s1, bt_s2;
	logic [31:0]     p_c, pp_c;
	assign p_c  = dv_tag[0] ? 32'd0 : (dv_quot << 1);
	assign pp_c = mul32(p_c >> 3, p_c >> 3);
	always_ff @(posedge clk) begin
		if (en) begin
			bp_s1 <= p_c;
			bu_s1 <= pp_c >> 13;
			bv_s1 <= mul32(p_c >> 2, p8);
			bt_s1 <= dv_tag;
		end
	end

	// Back stage 2: P9 product and final add.
	logic [31:0] bp_s2, bu_s2, bv_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			bp_s2 <= bp_s1;
			bu_s2 <= asr32(mul32(p9, bu_s1), 12);
			bv_s2 <= asr32(bv_s1, 13);
			bt_s2 <= bt_s1;
		end
	end

	logic [31:0] pfin_c;
	assign pfin_c = bt_s2[0] ? 32'd0 : bp_s2 + asr32(bu_s2 + bv_s2 + p7, 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_v_s1 <= 1'b0; b_v_s2 <= 1'b0; b_v_s3 <= 1'b0;
		end else if (en) begin
			b_v_s1 <= dv_valid; b_v_s2 <= b_v_s1; b_v_s3 <= b_v_s2;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			temp_centideg <= bt_s2[TagW-1 -: 16];
			humidity_q10  <= bt_s2[17:1];
			divide_error  <= bt_s2[0];
			pressure_pa   <= pfin_c;
		end
	end

	assign out_valid = b_v_s3;

endmodule
